[src/ditc_pkg.sv]
// Package for the two-door interlock controller.
// Holds the phase, event and message codes and the decision struct.
// No dependencies.
package ditc_pkg;

  // Field widths
  localparam int EventW  = 4;
  localparam int MsgW    = 5;
  localparam int PhaseW  = 4;
  localparam int IdW     = 32;
  localparam int WeightW = 16;

  // Sequencer phases
  localparam logic [PhaseW-1:0] PH_START        = 4'd0;
  localparam logic [PhaseW-1:0] PH_LEFT_LOCK    = 4'd1;
  localparam logic [PhaseW-1:0] PH_RIGHT_LOCK   = 4'd2;
  localparam logic [PhaseW-1:0] PH_LEFT_UNLOCK  = 4'd3;
  localparam logic [PhaseW-1:0] PH_RIGHT_UNLOCK = 4'd4;
  localparam logic [PhaseW-1:0] PH_OPENED       = 4'd5;
  localparam logic [PhaseW-1:0] PH_WEIGHED      = 4'd6;
  localparam logic [PhaseW-1:0] PH_LEFT_CLOSED  = 4'd7;
  localparam logic [PhaseW-1:0] PH_RIGHT_CLOSED = 4'd8;

  // Event codes
  localparam logic [EventW-1:0] EV_LS   = 4'd0;
  localparam logic [EventW-1:0] EV_RS   = 4'd1;
  localparam logic [EventW-1:0] EV_WS   = 4'd2;
  localparam logic [EventW-1:0] EV_LO   = 4'd3;
  localparam logic [EventW-1:0] EV_RO   = 4'd4;
  localparam logic [EventW-1:0] EV_LC   = 4'd5;
  localparam logic [EventW-1:0] EV_RC   = 4'd6;
  localparam logic [EventW-1:0] EV_GRU  = 4'd7;
  localparam logic [EventW-1:0] EV_GRL  = 4'd8;
  localparam logic [EventW-1:0] EV_GLL  = 4'd9;
  localparam logic [EventW-1:0] EV_GLU  = 4'd10;
  localparam logic [EventW-1:0] EV_EXIT = 4'd11;

  // Error and exit messages
  localparam logic [MsgW-1:0] ER_SCAN   = 5'd11;
  localparam logic [MsgW-1:0] ER_UNLOCK = 5'd12;
  localparam logic [MsgW-1:0] ER_OPEN   = 5'd13;
  localparam logic [MsgW-1:0] ER_WOC    = 5'd14;
  localparam logic [MsgW-1:0] ER_CLOSE  = 5'd15;
  localparam logic [MsgW-1:0] ER_LOCK   = 5'd16;
  localparam logic [MsgW-1:0] MSG_EXIT  = 5'd17;

  // One result item
  typedef struct packed {
    logic [MsgW-1:0]    message;
    logic               is_error;
    logic               waiting_again;
    logic [IdW-1:0]     shown_id;
    logic [WeightW-1:0] shown_weight;
  } result_t;

  // Decision for one request: result plus the state it leaves
  typedef struct packed {
    result_t           res;
    logic [PhaseW-1:0] next_phase;
    logic              next_weighed;
  } decision_t;

endpackage

[src/two_door_interlock_controller_unit.sv]
// Top level of the two-door interlock controller: state and result registers.
// Depends on ditc_pkg and ditc_decide.
//
//   channel | ports                                        | direction
//   in      | in_valid/in_ready, event_req, direction, id, weight | request in
//   out     | out_valid/out_ready, message, flags, id, weight    | result out
//
// Each request is decided as it is accepted and its result is registered,
// visible the next cycle. One request per cycle is sustained while out_ready
// is high; the phase and weighed-flag registers loop back through the decider.
// Synchronous active-low reset puts the sequencer in the start phase, clears
// the weighed flag and empties the result register.
// A stalled result holds; a new request is taken in the cycle the result leaves.
module two_door_interlock_controller_unit import ditc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [EventW-1:0]  in_event_req,
  input  logic               in_direction,
  input  logic [IdW-1:0]     in_person_id,
  input  logic [WeightW-1:0] in_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MsgW-1:0]    out_message,
  output logic               out_is_error,
  output logic               out_waiting_again,
  output logic [IdW-1:0]     out_shown_id,
  output logic [WeightW-1:0] out_shown_weight
);

  logic [PhaseW-1:0] phase_r;
  logic              weighed_r;
  logic              out_valid_r;
  result_t           res_r;
  decision_t         dec;
  logic              in_fire;

  // Decision logic on the incoming request
  ditc_decide u_decide (
    .phase     (phase_r),
    .weighed   (weighed_r),
    .event_req (in_event_req),
    .direction (in_direction),
    .person_id (in_person_id),
    .weight    (in_weight),
    .dec       (dec)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Sequencer state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      weighed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r   <= dec.next_phase;
        weighed_r <= dec.next_weighed;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= dec.res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_message       = res_r.message;
  assign out_is_error      = res_r.is_error;
  assign out_waiting_again = res_r.waiting_again;
  assign out_shown_id      = res_r.shown_id;
  assign out_shown_weight  = res_r.shown_weight;

endmodule

[src/ditc_decide.sv]
// Next-state and message decision for one interlock request.
// Depends on ditc_pkg.
module ditc_decide import ditc_pkg::*; (
  input  logic [PhaseW-1:0]  phase,
  input  logic               weighed,
  input  logic [EventW-1:0]  event_req,
  input  logic               direction,
  input  logic [IdW-1:0]     person_id,
  input  logic [WeightW-1:0] weight,
  output decision_t          dec
);

  logic              ok;
  logic              done;
  logic [MsgW-1:0]   err_msg;
  logic [PhaseW-1:0] nxt;
  logic              nxt_weighed;
  logic              show_id;
  logic              show_wt;
  // Left-side steps are allowed when outbound matches the weighed flag.
  logic              left_ok;
  logic              right_ok;

  assign left_ok  = (direction == weighed);
  assign right_ok = (direction != weighed);

  // Phase table: an unexpected event gives the phase's error kind.
  always_comb begin
    ok          = 1'b0;
    done        = 1'b0;
    nxt         = phase;
    nxt_weighed = weighed;
    show_id     = 1'b0;
    show_wt     = 1'b0;
    case (phase)
      PH_LEFT_LOCK: begin
        err_msg = ER_UNLOCK;
        if (event_req == EV_GLU && left_ok) begin
          ok = 1'b1; nxt = PH_LEFT_UNLOCK;
        end
      end
      PH_RIGHT_LOCK: begin
        err_msg = ER_UNLOCK;
        if (event_req == EV_GRU && right_ok) begin
          ok = 1'b1; nxt = PH_RIGHT_UNLOCK;
        end
      end
      PH_LEFT_UNLOCK: begin
        err_msg = ER_OPEN;
        if (event_req == EV_LO && left_ok) begin
          ok = 1'b1; nxt = PH_OPENED;
        end
      end
      PH_RIGHT_UNLOCK: begin
        err_msg = ER_OPEN;
        if (event_req == EV_RO && right_ok) begin
          ok = 1'b1; nxt = PH_OPENED;
        end
      end
      PH_OPENED: begin
        err_msg = ER_WOC;
        if (event_req == EV_WS && !weighed) begin
          ok = 1'b1; nxt = PH_WEIGHED; nxt_weighed = 1'b1; show_wt = 1'b1;
        end else if (event_req == EV_RC && !direction && weighed) begin
          ok = 1'b1; nxt = PH_RIGHT_CLOSED;
        end else if (event_req == EV_LC && direction && weighed) begin
          ok = 1'b1; nxt = PH_LEFT_CLOSED;
        end
      end
      PH_WEIGHED: begin
        err_msg = ER_CLOSE;
        if (event_req == EV_LC && !direction) begin
          ok = 1'b1; nxt = PH_LEFT_CLOSED;
        end else if (event_req == EV_RC && direction) begin
          ok = 1'b1; nxt = PH_RIGHT_CLOSED;
        end
      end
      PH_LEFT_CLOSED: begin
        err_msg = ER_LOCK;
        if (event_req == EV_GLL) begin
          ok = 1'b1;
          if (!direction) begin
            nxt = PH_RIGHT_LOCK;
          end else begin
            nxt = PH_START; done = 1'b1; nxt_weighed = 1'b0;
          end
        end
      end
      PH_RIGHT_CLOSED: begin
        err_msg = ER_LOCK;
        if (event_req == EV_GRL) begin
          ok = 1'b1;
          if (direction) begin
            nxt = PH_LEFT_LOCK;
          end else begin
            nxt = PH_START; done = 1'b1; nxt_weighed = 1'b0;
          end
        end
      end
      // Start phase, and any phase code outside the nine phases.
      default: begin
        err_msg = ER_SCAN;
        if (event_req == EV_LS) begin
          ok = 1'b1; nxt = PH_LEFT_LOCK; show_id = 1'b1;
        end else if (event_req == EV_RS) begin
          ok = 1'b1; nxt = PH_RIGHT_LOCK; show_id = 1'b1;
        end
      end
    endcase
  end

  // Exit overrides everything and leaves the state alone.
  always_comb begin
    if (event_req == EV_EXIT) begin
      dec.res.message       = MSG_EXIT;
      dec.res.is_error      = 1'b0;
      dec.res.waiting_again = 1'b0;
      dec.res.shown_id      = '0;
      dec.res.shown_weight  = '0;
      dec.next_phase        = phase;
      dec.next_weighed      = weighed;
    end else begin
      dec.res.message       = ok ? {{(MsgW-EventW){1'b0}}, event_req} : err_msg;
      dec.res.is_error      = !ok;
      dec.res.waiting_again = done;
      dec.res.shown_id      = show_id ? person_id : '0;
      dec.res.shown_weight  = show_wt ? weight : '0;
      dec.next_phase        = ok ? nxt : phase;
      dec.next_weighed      = ok ? nxt_weighed : weighed;
    end
  end

endmodule

[src/ditc_checker.sv]
// Port-level checks for the two-door interlock controller, bound to the top.
// Depends on ditc_pkg and two_door_interlock_controller_unit.
module ditc_checker import ditc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MsgW-1:0]    out_message,
  input logic               out_is_error,
  input logic               out_waiting_again,
  input logic [IdW-1:0]     out_shown_id,
  input logic [WeightW-1:0] out_shown_weight
);

  // A stalled result holds its message.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_message))
    else $error("stalled result changed");

  // Errors carry an error kind.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |->
      out_message >= ER_SCAN && out_message <= ER_LOCK)
    else $error("error flag without error kind");

  // A finished passage ends on an accepted guard lock.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_waiting_again |->
      !out_is_error && (out_message == {1'b0, EV_GRL} || out_message == {1'b0, EV_GLL}))
    else $error("waiting flag on wrong message");

  // Id and weight appear only on scans and weighing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_shown_id != '0 || out_shown_weight != '0) |->
      out_message == {1'b0, EV_LS} || out_message == {1'b0, EV_RS} ||
      out_message == {1'b0, EV_WS})
    else $error("echoed field on wrong message");

  // A request is taken whenever the result side is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind two_door_interlock_controller_unit ditc_checker u_ditc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_message       (out_message),
  .out_is_error      (out_is_error),
  .out_waiting_again (out_waiting_again),
  .out_shown_id      (out_shown_id),
  .out_shown_weight  (out_shown_weight)
);
